FILE: hw/rtl/pcsp_pkg.sv
// pcsp_pkg: shared types and constants of the PNG chunk stream parser.
// No dependencies; imported by every module of the parser.
package pcsp_pkg;

    // Parse phase
    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_BODY = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5
    } pcsp_phase_t;

    // Status codes as seen on the status port
    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_END     = 2'd1,
        ST_BADSIG  = 2'd2,
        ST_BADIHDR = 2'd3
    } pcsp_status_t;

    localparam logic [7:0]  SIG_BYTES [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                              8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
    localparam logic [31:0] IHDR_LEN  = 32'd13;

    // One result
    typedef struct packed {
        logic         payload_valid;
        logic [7:0]   payload_byte;
        logic         header_done;
        logic [31:0]  width;
        logic [31:0]  height;
        logic [7:0]   pixel_depth;
        logic [7:0]   pixel_format;
        logic [7:0]   compression_method;
        logic [7:0]   filter_method;
        logic [7:0]   interlace_method;
        pcsp_status_t status;
    } pcsp_result_t;

endpackage

FILE: hw/rtl/png_chunk_stream_parser_core.sv
// png_chunk_stream_parser_core: PNG signature check, chunk walk, IHDR capture,
// IDAT payload out. Uses pcsp_pkg, pcsp_parser, pcsp_result_reg.
// Result valid in the cycle after request accept. Throughput is 1 byte per
// clock while result_ready is high, set by the single-step parser logic.
// A new request is taken while the result register is empty or being drained.
// Reset (rst_n low, async): phase back to signature check, all captures zero.
module png_chunk_stream_parser_core
    import pcsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    // request side
    input  logic         data_valid,
    output logic         data_ready,
    input  logic [7:0]   data_byte,

    // result side
    output logic         result_valid,
    input  logic         result_ready,
    output logic         payload_valid,
    output logic [7:0]   payload_byte,
    output logic         header_done,
    output logic [31:0]  width,
    output logic [31:0]  height,
    output logic [7:0]   pixel_depth,
    output logic [7:0]   pixel_format,
    output logic [7:0]   compression_method,
    output logic [7:0]   filter_method,
    output logic [7:0]   interlace_method,
    output logic [1:0]   status
);

    logic         step;
    pcsp_result_t step_result;
    pcsp_result_t out_result;
    pcsp_phase_t  phase;

    // The result register frees up in the same cycle it is drained, so a
    // steady stream runs at one byte per clock with result_ready held high.
    assign data_ready = !result_valid || result_ready;
    assign step       = data_valid && data_ready;

    // Parser: state advances on every accepted request; the result it builds
    // reflects the state after that byte.
    pcsp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (data_byte),
        .result    (step_result),
        .phase     (phase)
    );

    // Result register: one entry, loaded on accept, cleared when taken.
    pcsp_result_reg u_result (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (step),
        .d     (step_result),
        .take  (result_ready),
        .valid (result_valid),
        .q     (out_result)
    );

    assign payload_valid      = out_result.payload_valid;
    assign payload_byte       = out_result.payload_byte;
    assign header_done        = out_result.header_done;
    assign width              = out_result.width;
    assign height             = out_result.height;
    assign pixel_depth        = out_result.pixel_depth;
    assign pixel_format       = out_result.pixel_format;
    assign compression_method = out_result.compression_method;
    assign filter_method      = out_result.filter_method;
    assign interlace_method   = out_result.interlace_method;
    assign status             = out_result.status;

    // Once ended or failed, the parser never resumes.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase == PH_DONE |=> phase == PH_DONE)
        else $error("parser left the done phase");

    // Payload only while parsing is still running.
    a_payload_running: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && payload_valid |-> status == ST_RUN)
        else $error("payload flagged with a terminal status");

    // An empty result register never stalls the request side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> data_ready)
        else $error("request stalled with empty result register");

    // An accepted request always produces a result next cycle.
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && data_ready |=> result_valid)
        else $error("accepted request produced no result");

endmodule

FILE: hw/rtl/pcsp_parser.sv
// pcsp_parser: chunk walker state and IHDR capture registers.
// Advances one byte per step; builds the result from the post-step state.
// Depends on pcsp_pkg.
module pcsp_parser
    import pcsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   data_byte,
    output pcsp_result_t result,
    output pcsp_phase_t  phase
);

    pcsp_phase_t  phase_reg, phase_next;
    pcsp_status_t status_reg, status_next;
    logic [31:0]  byte_count_reg, byte_count_next;
    logic [31:0]  chunk_length_reg, chunk_length_next;
    logic [31:0]  chunk_type_reg, chunk_type_next;
    logic [31:0]  image_width_reg, image_width_next;
    logic [31:0]  image_height_reg, image_height_next;
    logic [39:0]  header_bytes_reg, header_bytes_next;
    logic         header_seen_reg, header_seen_next;

    logic         pv;
    logic [7:0]   pb;
    logic [31:0]  type_word;
    logic [31:0]  count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SIG;
            status_reg       <= ST_RUN;
            byte_count_reg   <= '0;
            chunk_length_reg <= '0;
            chunk_type_reg   <= '0;
            image_width_reg  <= '0;
            image_height_reg <= '0;
            header_bytes_reg <= '0;
            header_seen_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            status_reg       <= status_next;
            byte_count_reg   <= byte_count_next;
            chunk_length_reg <= chunk_length_next;
            chunk_type_reg   <= chunk_type_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            header_bytes_reg <= header_bytes_next;
            header_seen_reg  <= header_seen_next;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        status_next       = status_reg;
        byte_count_next   = byte_count_reg;
        chunk_length_next = chunk_length_reg;
        chunk_type_next   = chunk_type_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        header_bytes_next = header_bytes_reg;
        header_seen_next  = header_seen_reg;
        pv                = 1'b0;
        pb                = 8'h00;
        type_word         = {chunk_type_reg[23:0], data_byte};
        count_inc         = byte_count_reg + 32'd1;

        unique case (phase_reg)
            PH_SIG:
            begin
                if (data_byte != SIG_BYTES[byte_count_reg[2:0]])
                begin
                    status_next = ST_BADSIG;
                    phase_next  = PH_DONE;
                end
                else if (byte_count_reg >= 32'd7)
                begin
                    byte_count_next = '0;
                    phase_next      = PH_LEN;
                end
                else
                begin
                    byte_count_next = count_inc;
                end
            end
            PH_LEN:
            begin
                chunk_length_next = {chunk_length_reg[23:0], data_byte};
                if (byte_count_reg >= 32'd3)
                begin
                    byte_count_next = '0;
                    chunk_type_next = '0;
                    phase_next      = PH_TYPE;
                end
                else
                begin
                    byte_count_next = count_inc;
                end
            end
            PH_TYPE:
            begin
                chunk_type_next = type_word;
                if (byte_count_reg < 32'd3)
                begin
                    byte_count_next = count_inc;
                end
                else
                begin
                    byte_count_next = '0;
                    if (type_word == TYPE_IEND || type_word == 32'd0)
                    begin
                        status_next = ST_END;
                        phase_next  = PH_DONE;
                    end
                    else if (type_word == TYPE_IHDR && chunk_length_reg != IHDR_LEN)
                    begin
                        status_next = ST_BADIHDR;
                        phase_next  = PH_DONE;
                    end
                    else
                    begin
                        if (type_word == TYPE_IHDR)
                        begin
                            header_seen_next = 1'b0;
                        end
                        phase_next = (chunk_length_reg == 32'd0) ? PH_CRC : PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if (chunk_type_reg == TYPE_IHDR)
                begin
                    if (byte_count_reg < 32'd4)
                    begin
                        image_width_next = {image_width_reg[23:0], data_byte};
                    end
                    else if (byte_count_reg < 32'd8)
                    begin
                        image_height_next = {image_height_reg[23:0], data_byte};
                    end
                    else
                    begin
                        header_bytes_next = {header_bytes_reg[31:0], data_byte};
                    end
                    if (byte_count_reg == IHDR_LEN - 32'd1)
                    begin
                        header_seen_next = 1'b1;
                    end
                end
                else if (chunk_type_reg == TYPE_IDAT)
                begin
                    pv = 1'b1;
                    pb = data_byte;
                end
                if (count_inc == chunk_length_reg)
                begin
                    byte_count_next = '0;
                    phase_next      = PH_CRC;
                end
                else
                begin
                    byte_count_next = count_inc;
                end
            end
            PH_CRC:
            begin
                if (byte_count_reg >= 32'd3)
                begin
                    byte_count_next   = '0;
                    chunk_length_next = '0;
                    phase_next        = PH_LEN;
                end
                else
                begin
                    byte_count_next = count_inc;
                end
            end
            default:
            begin
                // ended or failed: hold everything
            end
        endcase
    end

    always_comb
    begin
        result.payload_valid      = pv;
        result.payload_byte       = pb;
        result.header_done        = header_seen_next;
        result.width              = image_width_next;
        result.height             = image_height_next;
        result.pixel_depth        = header_bytes_next[39:32];
        result.pixel_format       = header_bytes_next[31:24];
        result.compression_method = header_bytes_next[23:16];
        result.filter_method      = header_bytes_next[15:8];
        result.interlace_method   = header_bytes_next[7:0];
        result.status             = status_next;
    end

    assign phase = phase_reg;

endmodule

FILE: hw/rtl/pcsp_result_reg.sv
// pcsp_result_reg: output register for one result, valid/ready on the far side.
// Depends on pcsp_pkg.
module pcsp_result_reg
    import pcsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  pcsp_result_t d,
    input  logic         take,
    output logic         valid,
    output pcsp_result_t q
);

    logic         valid_reg, valid_next;
    pcsp_result_t q_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= d;
        end
    end

    assign valid = valid_reg;
    assign q     = q_reg;

endmodule
